// File: rtl/sap_pkg.sv
// Shared types and constants for the shelf atlas packer.
package sap_pkg;

  localparam logic OP_PLACE = 1'b0;
  localparam logic OP_PIXEL = 1'b1;

  typedef enum logic [1:0] {
    ST_PLACED  = 2'd0,
    ST_NO_ROOM = 2'd1,
    ST_PIXEL   = 2'd2,
    ST_IGNORED = 2'd3
  } status_t;

  localparam int COL_W  = 11;
  localparam int ROW_W  = 14;
  localparam int ADDR_W = 23;

  localparam logic [COL_W-1:0] COL_SAT = 11'd2047;
  localparam logic [ROW_W-1:0] ROW_SAT = 14'd16383;

  // Depth of the queue between the front and the back.
  localparam int Q_DEPTH = 2;

  typedef struct packed {
    logic       opcode;
    logic [7:0] glyph_width;
    logic [7:0] glyph_height;
    logic [7:0] coverage;
  } in_word_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [9:0]        origin_x;
    logic [12:0]       origin_y;
    logic [13:0]       atlas_rows;
    logic              grew;
    logic [ADDR_W-1:0] write_address;
    logic [7:0]        write_value;
    logic              last;
  } out_word_t;

  typedef struct packed {
    logic       is_place;
    logic       size_ok;
    logic [7:0] w;
    logic [7:0] h;
    logic [7:0] cov;
  } cmd_t;

endpackage

// File: rtl/sap_front.sv
// Input front: takes request words and classifies them into queue commands.
module sap_front #(
  parameter int MAX_GLYPH = 255
) (
  input  logic              req_valid,
  output logic              req_ready,
  input  sap_pkg::in_word_t req,
  input  logic              q_full,
  output logic              push,
  output sap_pkg::cmd_t     cmd
);
  import sap_pkg::*;

  localparam int GB = $clog2(MAX_GLYPH + 1);
  localparam int GW = (GB > 8) ? GB : 8;
  localparam logic [GW-1:0] MAXG = GW'(MAX_GLYPH);

  logic w_ok;
  logic h_ok;

  assign req_ready = !q_full;
  assign push      = req_valid && req_ready;

  // A glyph size is usable only when both sides are nonzero and within the limit.
  assign w_ok = (req.glyph_width != 8'd0) && (GW'(req.glyph_width) <= MAXG);
  assign h_ok = (req.glyph_height != 8'd0) && (GW'(req.glyph_height) <= MAXG);

  always_comb begin
    cmd.is_place = (req.opcode == OP_PLACE);
    cmd.size_ok  = w_ok && h_ok;
    cmd.w        = req.glyph_width;
    cmd.h        = req.glyph_height;
    cmd.cov      = req.coverage;
  end

endmodule

// File: rtl/sap_queue.sv
// Short command queue that decouples the front from the back.
module sap_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  sap_pkg::cmd_t push_cmd,
  input  logic          pop,
  output logic          full,
  output logic          not_empty,
  output sap_pkg::cmd_t head
);
  import sap_pkg::*;

  localparam int PW = $clog2(Q_DEPTH);
  localparam int CW = $clog2(Q_DEPTH + 1);

  cmd_t          slots [Q_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign full      = (count == CW'(Q_DEPTH));
  assign not_empty = (count != '0);
  assign head      = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

// File: rtl/sap_back.sv
// Execution back end: shelf allocation, pixel addressing and the result register.
module sap_back #(
  parameter int ATLAS_WIDTH  = 1024,
  parameter int START_HEIGHT = 1024,
  parameter int MAX_HEIGHT   = 8192,
  parameter int PAD          = 2
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_valid,
  input  sap_pkg::cmd_t      cmd,
  output logic               pop,
  output logic               rsp_valid,
  input  logic               rsp_ready,
  output sap_pkg::out_word_t rsp
);
  import sap_pkg::*;

  localparam int HW  = $clog2(MAX_HEIGHT + 1);
  localparam int AWB = $clog2(ATLAS_WIDTH + 1);
  localparam int XW  = (AWB > 12) ? AWB : 12;
  localparam int YW  = (HW + 1 > 15) ? HW + 1 : 15;
  localparam int PRW = 15 + AWB;

  localparam logic [XW-1:0]  AW_X   = XW'(ATLAS_WIDTH);
  localparam logic [XW-1:0]  PAD_X  = XW'(PAD);
  localparam logic [YW-1:0]  PAD_Y  = YW'(PAD);
  localparam logic [YW-1:0]  MAXH_Y = YW'(MAX_HEIGHT);
  localparam logic [14:0]    PAD_R  = 15'(PAD);
  localparam logic [PRW-1:0] AW_P   = PRW'(ATLAS_WIDTH);

  // Allocator and streaming state.
  logic [COL_W-1:0] shelf_col, shelf_col_next;
  logic [ROW_W-1:0] shelf_row, shelf_row_next;
  logic [7:0]       shelf_tallest, shelf_tallest_next;
  logic [HW-1:0]    atlas_h, atlas_h_next;
  logic             active, active_next;
  logic [7:0]       w_held, w_held_next;
  logic [7:0]       h_held, h_held_next;
  logic [COL_W-1:0] base_x, base_x_next;
  logic [ROW_W-1:0] base_y, base_y_next;
  logic [7:0]       pix_row, pix_row_next;
  logic [7:0]       pix_col, pix_col_next;

  out_word_t        res;
  logic             fire;

  logic [XW-1:0]    col_now_sum;
  logic             move;
  logic [14:0]      row_step;
  logic [ROW_W-1:0] row_moved;
  logic [ROW_W-1:0] row_eff;
  logic [COL_W-1:0] col_eff;
  logic [7:0]       tall_eff;
  logic [XW-1:0]    col_adv;
  logic [COL_W-1:0] col_adv_sat;
  logic             x_ok;
  logic [YW-1:0]    need;
  logic [YW-1:0]    h_now;
  logic [YW-1:0]    h_dbl;
  logic [14:0]      row_sum;
  logic [11:0]      col_sum;
  logic [PRW-1:0]   prod;
  logic [ADDR_W-1:0] addr;
  logic             col_wrap;
  logic             row_wrap;
  logic             ok;

  assign fire = q_valid && (!rsp_valid || rsp_ready);
  assign pop  = fire;

  // A glyph that overruns the current shelf opens a new shelf below the tallest glyph.
  assign col_now_sum = XW'(shelf_col) + XW'(cmd.w) + PAD_X;
  assign move        = col_now_sum > AW_X;
  assign row_step    = 15'(shelf_row) + 15'(shelf_tallest) + PAD_R;
  assign row_moved   = (row_step > 15'(ROW_SAT)) ? ROW_SAT : row_step[ROW_W-1:0];
  assign row_eff     = move ? row_moved : shelf_row;
  assign col_eff     = move ? COL_W'(PAD) : shelf_col;
  assign tall_eff    = move ? 8'd0 : shelf_tallest;
  assign col_adv     = XW'(col_eff) + XW'(cmd.w) + PAD_X;
  assign x_ok        = col_adv <= AW_X;
  assign col_adv_sat = (col_adv > XW'(COL_SAT)) ? COL_SAT : col_adv[COL_W-1:0];
  assign need        = YW'(row_eff) + YW'(cmd.h) + PAD_Y;
  assign h_now       = YW'(atlas_h);
  assign h_dbl       = h_now << 1;

  // Pixel address is (base_y + row) * width + base_x + column.
  assign row_sum  = 15'(base_y) + 15'(pix_row);
  assign col_sum  = 12'(base_x) + 12'(pix_col);
  assign prod     = PRW'(row_sum) * AW_P;
  assign addr     = ADDR_W'(prod + PRW'(col_sum));
  assign col_wrap = (9'(pix_col) + 9'd1) >= 9'(w_held);
  assign row_wrap = (9'(pix_row) + 9'd1) >= 9'(h_held);

  always_comb begin
    shelf_col_next     = shelf_col;
    shelf_row_next     = shelf_row;
    shelf_tallest_next = shelf_tallest;
    atlas_h_next       = atlas_h;
    active_next        = active;
    w_held_next        = w_held;
    h_held_next        = h_held;
    base_x_next        = base_x;
    base_y_next        = base_y;
    pix_row_next       = pix_row;
    pix_col_next       = pix_col;
    ok                 = 1'b0;

    res               = '0;
    res.status        = ST_NO_ROOM;

    if (cmd.is_place) begin
      active_next = 1'b0;
      if (cmd.size_ok) begin
        if (move) begin
          shelf_row_next     = row_moved;
          shelf_col_next     = col_eff;
          shelf_tallest_next = 8'd0;
        end
        if (x_ok) begin
          if (need <= h_now) begin
            ok = 1'b1;
          end else if (h_dbl <= MAXH_Y) begin
            // The atlas grows once even if the glyph still does not fit.
            atlas_h_next = HW'(h_dbl);
            res.grew     = 1'b1;
            ok           = (need <= h_dbl);
          end
        end
        if (ok) begin
          res.status         = ST_PLACED;
          res.origin_x       = 10'(col_eff);
          res.origin_y       = 13'(row_eff);
          base_x_next        = col_eff;
          base_y_next        = row_eff;
          w_held_next        = cmd.w;
          h_held_next        = cmd.h;
          pix_row_next       = 8'd0;
          pix_col_next       = 8'd0;
          active_next        = 1'b1;
          shelf_col_next     = col_adv_sat;
          shelf_tallest_next = (cmd.h > tall_eff) ? cmd.h : tall_eff;
        end
      end
    end else if (!active) begin
      res.status = ST_IGNORED;
    end else begin
      res.status        = ST_PIXEL;
      res.write_address = addr;
      res.write_value   = cmd.cov;
      if (col_wrap) begin
        pix_col_next = 8'd0;
        if (row_wrap) begin
          res.last     = 1'b1;
          active_next  = 1'b0;
          pix_row_next = 8'd0;
        end else begin
          pix_row_next = pix_row + 8'd1;
        end
      end else begin
        pix_col_next = pix_col + 8'd1;
      end
    end

    res.atlas_rows = 14'(atlas_h_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      shelf_col     <= COL_W'(PAD);
      shelf_row     <= ROW_W'(PAD);
      shelf_tallest <= 8'd0;
      atlas_h       <= HW'(START_HEIGHT);
      active        <= 1'b0;
      pix_row       <= 8'd0;
      pix_col       <= 8'd0;
      rsp_valid     <= 1'b0;
    end else begin
      if (fire) begin
        shelf_col     <= shelf_col_next;
        shelf_row     <= shelf_row_next;
        shelf_tallest <= shelf_tallest_next;
        atlas_h       <= atlas_h_next;
        active        <= active_next;
        pix_row       <= pix_row_next;
        pix_col       <= pix_col_next;
        rsp_valid     <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Glyph geometry and the result word carry no reset.
  always_ff @(posedge clk) begin
    if (fire) begin
      w_held <= w_held_next;
      h_held <= h_held_next;
      base_x <= base_x_next;
      base_y <= base_y_next;
      rsp    <= res;
    end
  end

`ifndef SYNTHESIS
  a_fire_loads_result: assert property (@(posedge clk) disable iff (rst)
    fire |=> rsp_valid)
    else $error("result register not loaded after a command was executed");

  a_pixel_inside_glyph: assert property (@(posedge clk) disable iff (rst)
    active |-> (pix_col < w_held) && (pix_row < h_held))
    else $error("pixel counters ran outside the active glyph");

  a_height_bounded: assert property (@(posedge clk) disable iff (rst)
    YW'(atlas_h) <= MAXH_Y)
    else $error("atlas height exceeds its maximum");

  a_grew_on_place: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.grew |-> (rsp.status == ST_PLACED) || (rsp.status == ST_NO_ROOM))
    else $error("growth reported on a pixel word");

  a_held_result_stable: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> !pop || $past(q_valid) == 1'b0 || $stable(rsp))
    else $error("pending result overwritten while stalled");
`endif

endmodule

// File: rtl/shelf_atlas_packer.sv
// Top level of the shelf atlas packer: front, command queue and back end.
//
// Request channel (req_valid / req_ready / req): each word is either a place
// request (opcode 0, glyph width and height) or one coverage byte of the glyph
// that was placed last, in row-major order.
// Response channel (rsp_valid / rsp_ready / rsp): exactly one word per request
// word, in order: glyph origin or no room for a place request, atlas write
// address and value for a coverage byte, or ignored if no glyph is streaming.
// An accepted word is registered in the two-entry queue, then the back end loads
// the result register from the queue head, which presents it on rsp.
// Throughput: one word per cycle unless the receiver stalls; the back end does
// all shelf arithmetic and the pixel address multiply combinationally, so
// nothing iterates.
// Reset clears the shelves to the pad offset, sets the atlas height to
// START_HEIGHT and drops any glyph that was streaming.
// When the receiver stalls, the result register holds its word, the queue fills,
// and req_ready falls once both queue entries are taken.
module shelf_atlas_packer #(
  parameter int ATLAS_WIDTH  = 1024,
  parameter int START_HEIGHT = 1024,
  parameter int MAX_HEIGHT   = 8192,
  parameter int PAD          = 2,
  parameter int MAX_GLYPH    = 255
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_ready,
  input  sap_pkg::in_word_t  req,
  output logic               rsp_valid,
  input  logic               rsp_ready,
  output sap_pkg::out_word_t rsp
);
  import sap_pkg::*;

  cmd_t push_cmd;
  cmd_t head;
  logic push;
  logic pop;
  logic q_full;
  logic q_valid;

  sap_front #(
    .MAX_GLYPH (MAX_GLYPH)
  ) u_front (
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .q_full    (q_full),
    .push      (push),
    .cmd       (push_cmd)
  );

  sap_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_cmd  (push_cmd),
    .pop       (pop),
    .full      (q_full),
    .not_empty (q_valid),
    .head      (head)
  );

  sap_back #(
    .ATLAS_WIDTH  (ATLAS_WIDTH),
    .START_HEIGHT (START_HEIGHT),
    .MAX_HEIGHT   (MAX_HEIGHT),
    .PAD          (PAD)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .cmd       (head),
    .pop       (pop),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

endmodule
